@@ rtl/frs_pkg.sv @@
// shared types, constants and helper functions of the flat-split triangle rasteriser
package frs_pkg;

  localparam int COORD_FRAC_BITS = 4;
  localparam int SLOPE_FRAC_BITS = 16;
  localparam int MAX_SCREEN_DIM  = 2048;

  localparam int YW    = 16;
  localparam int XW    = 17;
  localparam int RW    = 13;
  localparam int DIMW  = 12;
  localparam int CW    = 12;
  localparam int PXW   = 11;
  localparam int DVD_W = SLOPE_FRAC_BITS + 18;
  localparam int DVS_W = YW + 1;
  localparam int SW    = DVD_W + 1;
  localparam int DW    = 20;
  localparam int NW    = SW + DW + 3;
  localparam int SHIFT = COORD_FRAC_BITS + 1 + SLOPE_FRAC_BITS;
  localparam int XLW   = NW - SHIFT;
  localparam int HALF  = 1 << COORD_FRAC_BITS;

  localparam logic CMD_LOAD = 1'b0;
  localparam logic CMD_STEP = 1'b1;

  localparam logic [0:0] REG_SCREEN_WIDTH  = 1'b0;
  localparam logic [0:0] REG_SCREEN_HEIGHT = 1'b1;

  localparam logic [DIMW-1:0] SCREEN_WIDTH_RST  = DIMW'(800);
  localparam logic [DIMW-1:0] SCREEN_HEIGHT_RST = DIMW'(600);

  typedef struct packed {
    logic              command;
    logic signed [15:0] vert_a_x;
    logic signed [15:0] vert_a_y;
    logic signed [15:0] vert_b_x;
    logic signed [15:0] vert_b_y;
    logic signed [15:0] vert_c_x;
    logic signed [15:0] vert_c_y;
    logic [31:0]        fill_color;
  } in_item_t;

  typedef struct packed {
    logic [PXW-1:0] pixel_x;
    logic [PXW-1:0] pixel_y;
    logic [31:0]    pixel_color;
    logic           pixel_valid;
    logic           raster_done;
  } out_item_t;

  typedef struct packed {
    logic signed [XW-1:0] x;
    logic signed [YW-1:0] y;
  } vtx_t;

  typedef struct packed {
    logic                 on;
    vtx_t                 lp;
    vtx_t                 lq;
    vtx_t                 rp;
    vtx_t                 rq;
    logic signed [RW-1:0] rb;
    logic signed [RW-1:0] re;
  } part_t;

  // ceil(y - 0.5) in pixel rows
  function automatic logic signed [RW-1:0] row_of(input logic signed [YW-1:0] y);
    logic signed [YW+1:0] t;
    t = ((YW+2)'(y) <<< 1) + (YW+2)'((2 * HALF) - 1 - HALF);
    return RW'(t >>> (COORD_FRAC_BITS + 1));
  endfunction

  function automatic part_t mk_bottom(input vtx_t a, input vtx_t l, input vtx_t r);
    part_t p;
    p.on = 1'b1;
    p.lp = a;
    p.lq = l;
    p.rp = a;
    p.rq = r;
    p.rb = row_of(a.y);
    p.re = row_of(l.y);
    return p;
  endfunction

  function automatic part_t mk_top(input vtx_t a, input vtx_t l, input vtx_t r);
    part_t p;
    p.on = 1'b1;
    p.lp = l;
    p.lq = a;
    p.rp = r;
    p.rq = a;
    p.rb = row_of(l.y);
    p.re = row_of(a.y);
    return p;
  endfunction

endpackage

@@ rtl/frs_front.sv @@
// input queue: holds accepted commands until the back end takes them
module frs_front (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              push,
  output logic              full,
  input  frs_pkg::in_item_t item_in,
  input  logic              pop,
  output logic              empty,
  output frs_pkg::in_item_t item_out
);
  import frs_pkg::*;

  in_item_t   ent_r [2];
  logic       wp_r;
  logic       rp_r;
  logic [1:0] cnt_r;
  logic       do_push;
  logic       do_pop;

  assign full     = (cnt_r == 2'd2);
  assign empty    = (cnt_r == 2'd0);
  assign item_out = ent_r[rp_r];
  assign do_push  = push && !full;
  assign do_pop   = pop && !empty;

  always_ff @(posedge clk) begin
    if (do_push) begin
      ent_r[wp_r] <= item_in;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= 1'b0;
      rp_r  <= 1'b0;
      cnt_r <= 2'd0;
    end else begin
      if (do_push) wp_r <= ~wp_r;
      if (do_pop) rp_r <= ~rp_r;
      cnt_r <= cnt_r + 2'(do_push) - 2'(do_pop);
    end
  end

endmodule

@@ rtl/frs_outq.sv @@
// result queue: decouples finished results from the consumer
module frs_outq (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               push,
  output logic               full,
  input  frs_pkg::out_item_t item_in,
  input  logic               pop,
  output logic               empty,
  output frs_pkg::out_item_t item_out
);
  import frs_pkg::*;

  out_item_t  ent_r [2];
  logic       wp_r;
  logic       rp_r;
  logic [1:0] cnt_r;
  logic       do_push;
  logic       do_pop;

  assign full     = (cnt_r == 2'd2);
  assign empty    = (cnt_r == 2'd0);
  assign item_out = ent_r[rp_r];
  assign do_push  = push && !full;
  assign do_pop   = pop && !empty;

  always_ff @(posedge clk) begin
    if (do_push) begin
      ent_r[wp_r] <= item_in;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= 1'b0;
      rp_r  <= 1'b0;
      cnt_r <= 2'd0;
    end else begin
      if (do_push) wp_r <= ~wp_r;
      if (do_pop) rp_r <= ~rp_r;
      cnt_r <= cnt_r + 2'(do_push) - 2'(do_pop);
    end
  end

endmodule

@@ rtl/frs_div.sv @@
// iterative restoring divider, one quotient bit per cycle
module frs_div (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      start,
  input  logic [frs_pkg::DVD_W-1:0] dividend,
  input  logic [frs_pkg::DVS_W-1:0] divisor,
  output logic                      done,
  output logic [frs_pkg::DVD_W-1:0] quotient
);
  import frs_pkg::*;

  localparam int CNTW = $clog2(DVD_W);

  logic [DVS_W-1:0] rem_r;
  logic [DVS_W-1:0] dvs_r;
  logic [DVD_W-1:0] q_r;
  logic [CNTW-1:0]  cnt_r;
  logic             busy_r;
  logic             done_r;
  logic [DVS_W:0]   trial;
  logic             fits;

  assign trial    = {rem_r, q_r[DVD_W-1]};
  assign fits     = (trial >= {1'b0, dvs_r});
  assign done     = done_r;
  assign quotient = q_r;

  always_ff @(posedge clk) begin
    if (start) begin
      rem_r <= '0;
      q_r   <= dividend;
      dvs_r <= divisor;
    end else if (busy_r) begin
      rem_r <= fits ? DVS_W'(trial - {1'b0, dvs_r}) : DVS_W'(trial);
      q_r   <= {q_r[DVD_W-2:0], fits};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= '0;
      end else if (busy_r) begin
        cnt_r <= cnt_r + 1'b1;
        if (cnt_r == CNTW'(DVD_W - 1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

endmodule

@@ rtl/frs_back.sv @@
// back end: triangle setup, edge stepping and span walking
module frs_back (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     in_empty,
  input  frs_pkg::in_item_t        in_item,
  output logic                     in_pop,
  input  logic [frs_pkg::DIMW-1:0] scr_w,
  input  logic [frs_pkg::DIMW-1:0] scr_h,
  input  logic                     res_full,
  output logic                     res_push,
  output frs_pkg::out_item_t       res
);
  import frs_pkg::*;

  localparam logic [3:0] S_IDLE  = 4'd0;
  localparam logic [3:0] S_SORT  = 4'd1;
  localparam logic [3:0] S_CLASS = 4'd2;
  localparam logic [3:0] S_SPDIV = 4'd3;
  localparam logic [3:0] S_SPLIT = 4'd4;
  localparam logic [3:0] S_ENTER = 4'd5;
  localparam logic [3:0] S_EDIV  = 4'd6;
  localparam logic [3:0] S_EMUL  = 4'd7;
  localparam logic [3:0] S_ROW   = 4'd8;
  localparam logic [3:0] S_EMIT  = 4'd9;

  localparam logic [1:0] PH_IDLE  = 2'd0;
  localparam logic [1:0] PH_UPPER = 2'd1;
  localparam logic [1:0] PH_LOWER = 2'd2;
  localparam logic [1:0] PH_DONE  = 2'd3;

  localparam int PW    = XW + YW + 2;
  localparam int MCW   = $clog2(DW + 1);
  localparam int DIMX  = DIMW + 1;

  logic [3:0]            state_r;
  logic [1:0]            phase_r;
  logic                  wait_r;
  logic                  ret_load_r;
  logic                  esel_r;
  in_item_t              item_r;
  logic [31:0]           color_r;
  vtx_t                  t_r;
  vtx_t                  m_r;
  vtx_t                  b_r;
  logic signed [PW-1:0]  prod_r;
  logic signed [XW-1:0]  split_r;
  part_t                 part_r [2];
  logic signed [SW-1:0]  slope_r;
  logic signed [NW-1:0]  mcand_r;
  logic [DW-1:0]         mpl_r;
  logic                  dneg_r;
  logic signed [NW-1:0]  acc_r;
  logic [MCW-1:0]        mcnt_r;
  logic signed [NW-1:0]  nl_r;
  logic signed [NW-1:0]  nr_r;
  logic signed [NW-1:0]  stl_r;
  logic signed [NW-1:0]  str_r;
  logic signed [RW-1:0]  row_r;
  logic signed [RW-1:0]  span_row_r;
  logic [CW-1:0]         col_r;
  logic [CW-1:0]         end_r;
  out_item_t             res_r;

  vtx_t                  va, vb, vc, s0, s1, s2, tmp;
  part_t                 cp;
  vtx_t                  ep, eq;
  logic signed [XW:0]    dx;
  logic signed [YW:0]    dy;
  logic [XW:0]           dx_mag;
  logic [YW:0]           dy_mag;
  logic signed [PW-1:0]  prod_mag;
  logic                  div_start;
  logic [DVD_W-1:0]      div_dvd;
  logic [DVS_W-1:0]      div_dvs;
  logic                  div_done;
  logic [DVD_W-1:0]      div_q;
  logic signed [SW-1:0]  slope_val;
  logic signed [XW:0]    split_val;
  logic signed [DW-1:0]  d_val;
  logic signed [NW-1:0]  base_val;
  logic signed [NW-1:0]  n_val;
  logic [DIMX-1:0]       w_eff;
  logic [DIMX-1:0]       h_eff;
  logic signed [NW-1:0]  rl_sum;
  logic signed [NW-1:0]  rr_sum;
  logic signed [XLW-1:0] xl;
  logic signed [XLW-1:0] xr;
  logic signed [XLW-1:0] lo;
  logic signed [XLW-1:0] hi;
  logic signed [XLW-1:0] w_s;
  logic signed [RW:0]    h_s;
  logic                  rows_over;
  logic                  active;
  logic                  part_on;
  vtx_t                  pi;

  // sort by y: top (s1), middle (s0), bottom (s2)
  always_comb begin
    va.x = XW'(item_r.vert_a_x);
    va.y = item_r.vert_a_y;
    vb.x = XW'(item_r.vert_b_x);
    vb.y = item_r.vert_b_y;
    vc.x = XW'(item_r.vert_c_x);
    vc.y = item_r.vert_c_y;
    tmp = va;
    s0 = va;
    s1 = vb;
    s2 = vc;
    if (s0.y < s1.y) begin
      tmp = s0; s0 = s1; s1 = tmp;
    end
    if (s2.y < s1.y) begin
      tmp = s2; s2 = s1; s1 = tmp;
    end
    if (s0.y > s2.y) begin
      tmp = s0; s0 = s2; s2 = tmp;
    end
  end

  assign active  = (phase_r == PH_UPPER) || (phase_r == PH_LOWER);
  assign cp      = part_r[phase_r[1]];
  assign part_on = active && cp.on;
  assign ep      = esel_r ? cp.rp : cp.lp;
  assign eq      = esel_r ? cp.rq : cp.lq;
  assign dx      = (XW+1)'(eq.x) - (XW+1)'(ep.x);
  assign dy      = (YW+1)'(eq.y) - (YW+1)'(ep.y);
  assign dx_mag  = dx[XW] ? (XW+1)'(-dx) : (XW+1)'(dx);
  assign dy_mag  = dy[YW] ? (YW+1)'(-dy) : (YW+1)'(dy);
  assign prod_mag = prod_r[PW-1] ? -prod_r : prod_r;

  assign div_start = ((state_r == S_SPDIV) || (state_r == S_EDIV)) && !wait_r;
  assign div_dvd   = (state_r == S_SPDIV) ? DVD_W'(prod_mag)
                                          : (DVD_W'(dx_mag) << SLOPE_FRAC_BITS);
  assign div_dvs   = (state_r == S_SPDIV) ? DVS_W'((YW+1)'(b_r.y) - (YW+1)'(t_r.y))
                                          : DVS_W'(dy_mag);

  frs_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (div_dvd),
    .divisor  (div_dvs),
    .done     (div_done),
    .quotient (div_q)
  );

  always_comb begin
    slope_val = (dx[XW] ^ dy[YW]) ? -SW'(div_q) : SW'(div_q);
    if (dy == '0) slope_val = '0;
    split_val = (XW+1)'(t_r.x) + (prod_r[PW-1] ? -(XW+1)'(div_q) : (XW+1)'(div_q));
    d_val     = (DW'(row_r) <<< (COORD_FRAC_BITS + 1)) + DW'(HALF) - (DW'(ep.y) <<< 1);
    base_val  = ((NW'(ep.x) <<< 1) - NW'(HALF)) <<< SLOPE_FRAC_BITS;
    n_val     = (dneg_r ? -acc_r : acc_r) + base_val;
    pi.x      = split_r;
    pi.y      = m_r.y;
  end

  // row test and span bounds
  always_comb begin
    w_eff     = (scr_w >= DIMW'(MAX_SCREEN_DIM)) ? DIMX'(MAX_SCREEN_DIM) : DIMX'(scr_w);
    h_eff     = (scr_h >= DIMW'(MAX_SCREEN_DIM)) ? DIMX'(MAX_SCREEN_DIM) : DIMX'(scr_h);
    w_s       = $signed(XLW'(w_eff));
    h_s       = $signed((RW+1)'(h_eff));
    rows_over = ((RW+1)'(row_r) >= (RW+1)'(cp.re)) || ((RW+1)'(row_r) >= h_s);
    rl_sum    = nl_r + NW'((1 << SHIFT) - 1);
    rr_sum    = nr_r + NW'((1 << SHIFT) - 1);
    xl        = XLW'(rl_sum >>> SHIFT);
    xr        = XLW'(rr_sum >>> SHIFT);
    lo        = (xl > 0) ? xl : '0;
    hi        = (xr < w_s) ? xr : w_s;
  end

  assign in_pop   = (state_r == S_IDLE) && !in_empty;
  assign res_push = (state_r == S_EMIT) && !res_full;
  assign res      = res_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= S_IDLE;
      phase_r    <= PH_IDLE;
      wait_r     <= 1'b0;
      ret_load_r <= 1'b0;
      esel_r     <= 1'b0;
      col_r      <= '0;
      end_r      <= '0;
    end else begin
      if (div_start) wait_r <= 1'b1;
      else if (div_done) wait_r <= 1'b0;
      unique case (state_r)
        S_IDLE: begin
          if (!in_empty) begin
            if (in_item.command == CMD_LOAD) begin
              item_r  <= in_item;
              color_r <= in_item.fill_color;
              state_r <= S_SORT;
            end else if (active && (col_r < end_r)) begin
              res_r   <= '{pixel_x: col_r[PXW-1:0], pixel_y: span_row_r[PXW-1:0],
                           pixel_color: color_r, pixel_valid: 1'b1, raster_done: 1'b0};
              col_r   <= col_r + 1'b1;
              state_r <= S_EMIT;
            end else if (active) begin
              ret_load_r <= 1'b0;
              state_r    <= S_ROW;
            end else begin
              res_r   <= '{pixel_x: PXW'(0), pixel_y: PXW'(0), pixel_color: 32'd0,
                           pixel_valid: 1'b0, raster_done: 1'b1};
              state_r <= S_EMIT;
            end
          end
        end
        S_SORT: begin
          t_r     <= s1;
          m_r     <= s0;
          b_r     <= s2;
          state_r <= S_CLASS;
        end
        S_CLASS: begin
          phase_r    <= PH_UPPER;
          ret_load_r <= 1'b1;
          if (m_r.y == t_r.y) begin
            part_r[0].on <= 1'b0;
            if (b_r.y != m_r.y) begin
              part_r[1] <= (m_r.x > t_r.x) ? mk_top(b_r, t_r, m_r) : mk_top(b_r, m_r, t_r);
            end else begin
              part_r[1].on <= 1'b0;
            end
            state_r <= S_ENTER;
          end else if (m_r.y == b_r.y) begin
            part_r[0] <= (m_r.x > b_r.x) ? mk_bottom(t_r, b_r, m_r)
                                         : mk_bottom(t_r, m_r, b_r);
            part_r[1].on <= 1'b0;
            state_r <= S_ENTER;
          end else begin
            prod_r  <= PW'((XW+1)'(b_r.x) - (XW+1)'(t_r.x))
                     * PW'((YW+1)'(m_r.y) - (YW+1)'(t_r.y));
            state_r <= S_SPDIV;
          end
        end
        S_SPDIV: begin
          if (wait_r && div_done) begin
            split_r <= XW'(split_val);
            state_r <= S_SPLIT;
          end
        end
        S_SPLIT: begin
          if (pi.x < m_r.x) begin
            part_r[0] <= mk_bottom(t_r, pi, m_r);
            part_r[1] <= mk_top(b_r, pi, m_r);
          end else begin
            part_r[0] <= mk_bottom(t_r, m_r, pi);
            part_r[1] <= mk_top(b_r, m_r, pi);
          end
          state_r <= S_ENTER;
        end
        S_ENTER: begin
          col_r <= '0;
          end_r <= '0;
          if (part_on) begin
            row_r   <= (cp.rb > 0) ? cp.rb : '0;
            esel_r  <= 1'b0;
            state_r <= S_EDIV;
          end else if (phase_r == PH_UPPER) begin
            phase_r <= PH_LOWER;
          end else begin
            phase_r <= PH_DONE;
            res_r   <= '{pixel_x: PXW'(0), pixel_y: PXW'(0), pixel_color: 32'd0,
                         pixel_valid: 1'b0, raster_done: !ret_load_r};
            state_r <= S_EMIT;
          end
        end
        S_EDIV: begin
          if (wait_r && div_done) begin
            slope_r <= slope_val;
            mcand_r <= NW'(slope_val);
            dneg_r  <= d_val[DW-1];
            mpl_r   <= d_val[DW-1] ? DW'(-d_val) : DW'(d_val);
            acc_r   <= '0;
            mcnt_r  <= '0;
            state_r <= S_EMUL;
          end
        end
        S_EMUL: begin
          if (mcnt_r == MCW'(DW)) begin
            if (esel_r) begin
              nr_r    <= n_val;
              str_r   <= NW'(slope_r) <<< (COORD_FRAC_BITS + 1);
              res_r   <= '0;
              state_r <= ret_load_r ? S_EMIT : S_ROW;
            end else begin
              nl_r    <= n_val;
              stl_r   <= NW'(slope_r) <<< (COORD_FRAC_BITS + 1);
              esel_r  <= 1'b1;
              state_r <= S_EDIV;
            end
          end else begin
            if (mpl_r[0]) acc_r <= acc_r + mcand_r;
            mcand_r <= mcand_r <<< 1;
            mpl_r   <= mpl_r >> 1;
            mcnt_r  <= mcnt_r + 1'b1;
          end
        end
        S_ROW: begin
          if (rows_over) begin
            phase_r <= phase_r + 1'b1;
            state_r <= S_ENTER;
          end else begin
            row_r <= row_r + 1'b1;
            nl_r  <= nl_r + stl_r;
            nr_r  <= nr_r + str_r;
            if (lo < hi) begin
              span_row_r <= row_r;
              col_r      <= CW'(lo) + 1'b1;
              end_r      <= CW'(hi);
              res_r      <= '{pixel_x: PXW'(lo), pixel_y: row_r[PXW-1:0],
                              pixel_color: color_r, pixel_valid: 1'b1, raster_done: 1'b0};
              state_r    <= S_EMIT;
            end
          end
        end
        S_EMIT: begin
          if (!res_full) state_r <= S_IDLE;
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

endmodule

@@ rtl/flat_split_triangle_rasterizer.sv @@
// top level of the flat-split triangle rasteriser
//
//   channel | direction | transfer when          | payload
//   in_     | in        | in_push && !in_full    | in_item  (frs_pkg::in_item_t)
//   out_    | out       | out_pop && !out_empty  | out_item (frs_pkg::out_item_t)
//   cfg_    | in        | cfg_we                 | cfg_addr, cfg_data
//
// commands are handled one at a time by the back end; a pixel step inside a span
// goes from the input queue through S_IDLE and S_EMIT into the result queue
// a load sorts the vertices, classifies the triangle and, if no edge is flat, does the split
// divide; each part entered then needs a divide and a shift-add multiply per edge
// each row walked passes through S_ROW; reset is synchronous, active low
// an input stall does not block output; an output stall holds S_EMIT, so the input queue fills
module flat_split_triangle_rasterizer (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     in_push,
  output logic                     in_full,
  input  frs_pkg::in_item_t        in_item,
  output logic                     out_empty,
  input  logic                     out_pop,
  output frs_pkg::out_item_t       out_item,
  input  logic                     cfg_we,
  input  logic [0:0]               cfg_addr,
  input  logic [frs_pkg::DIMW-1:0] cfg_data
);
  import frs_pkg::*;

  logic [DIMW-1:0] scr_w_r;
  logic [DIMW-1:0] scr_h_r;
  logic            fq_empty;
  in_item_t        fq_item;
  logic            fq_pop;
  logic            oq_full;
  logic            res_push;
  out_item_t       res;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      scr_w_r <= SCREEN_WIDTH_RST;
      scr_h_r <= SCREEN_HEIGHT_RST;
    end else if (cfg_we) begin
      unique case (cfg_addr)
        REG_SCREEN_WIDTH:  scr_w_r <= cfg_data;
        REG_SCREEN_HEIGHT: scr_h_r <= cfg_data;
        default:           scr_w_r <= scr_w_r;
      endcase
    end
  end

  frs_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (in_push),
    .full     (in_full),
    .item_in  (in_item),
    .pop      (fq_pop),
    .empty    (fq_empty),
    .item_out (fq_item)
  );

  frs_back u_back (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_empty (fq_empty),
    .in_item  (fq_item),
    .in_pop   (fq_pop),
    .scr_w    (scr_w_r),
    .scr_h    (scr_h_r),
    .res_full (oq_full),
    .res_push (res_push),
    .res      (res)
  );

  frs_outq u_outq (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (res_push),
    .full     (oq_full),
    .item_in  (res),
    .pop      (out_pop),
    .empty    (out_empty),
    .item_out (out_item)
  );

  a_push_space: assert property (@(posedge clk) disable iff (!rst_n)
    res_push |-> !oq_full)
    else $error("result written into a full queue");

  a_valid_done: assert property (@(posedge clk) disable iff (!rst_n)
    !out_empty |-> !(out_item.pixel_valid && out_item.raster_done))
    else $error("result is both pixel and done");

  a_on_screen: assert property (@(posedge clk) disable iff (!rst_n)
    (!out_empty && out_item.pixel_valid) |->
      (DIMW'(out_item.pixel_x) < scr_w_r && DIMW'(out_item.pixel_y) < scr_h_r))
    else $error("pixel outside screen");

endmodule
